@@ rtl/abrd_pkg.sv @@
// Package for the audio buffer ring DMA feeder: sizes, codes, request/response
// and state types, and small helper functions.
// No dependencies.
`default_nettype none

package abrd_pkg;

	localparam int NUM_BUFFERS = 8;
	localparam int PW          = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW          = $clog2(NUM_BUFFERS + 1);
	localparam int SW          = CW + 2;
	localparam int IDX_W       = 3;
	localparam int CNT_W       = 4;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int UR_W        = 16;

	typedef logic [PW-1:0]        ptr_t;
	typedef logic [CW-1:0]        fill_t;
	typedef logic signed [SW-1:0] sval_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		FN_CLAIM  = 2'd0,
		FN_REFILL = 2'd1,
		FN_SRESET = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		LD_NONE  = 2'd0,
		LD_FIRST = 2'd1,
		LD_NEXT  = 2'd2,
		LD_RSVD  = 2'd3
	} load_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       tx_first_empty;
		logic       tx_next_empty;
		logic       rx_first_empty;
		logic       rx_next_empty;
	} req_t;

	typedef struct packed {
		logic             granted;
		logic [IDX_W-1:0] buffer_index;
		logic [1:0]       dma_load;
		logic [1:0]       dma_command;
		logic [UR_W-1:0]  underrun_total;
		cnt_t             readable_count;
		cnt_t             writeable_count;
	} rsp_t;

	typedef struct packed {
		ptr_t            wp;
		ptr_t            rp;
		fill_t           filled;
		logic            halted;
		logic [UR_W-1:0] underrun;
	} state_t;

	localparam state_t STATE_RST = '{wp: '0, rp: '0, filled: '0, halted: 1'b1,
		underrun: '0};

	function automatic ptr_t ptr_inc(ptr_t p);
		if (p == PW'(NUM_BUFFERS - 1))
			return '0;
		return p + ptr_t'(1);
	endfunction

	function automatic sval_t busy_slots(logic first_empty, logic next_empty);
		if (!next_empty)
			return sval_t'(2);
		if (!first_empty)
			return sval_t'(1);
		return '0;
	endfunction

	function automatic cnt_t clamp_cnt(sval_t v);
		if (v < 0)
			return '0;
		if (v > sval_t'(CNT_MAX))
			return cnt_t'(CNT_MAX);
		return cnt_t'(v);
	endfunction

endpackage

`default_nettype wire

@@ rtl/abrd_req_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
`default_nettype none

interface abrd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       tx_first_empty;
	logic       tx_next_empty;
	logic       rx_first_empty;
	logic       rx_next_empty;

	modport source (output valid, func, tx_first_empty, tx_next_empty, rx_first_empty,
		rx_next_empty, input ready);
	modport sink (input valid, func, tx_first_empty, tx_next_empty, rx_first_empty,
		rx_next_empty, output ready);
endinterface

interface abrd_rsp_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [2:0]  buffer_index;
	logic [1:0]  dma_load;
	logic [1:0]  dma_command;
	logic [15:0] underrun_total;
	logic [3:0]  readable_count;
	logic [3:0]  writeable_count;

	modport source (output valid, granted, buffer_index, dma_load, dma_command,
		underrun_total, readable_count, writeable_count, input ready);
	modport sink (input valid, granted, buffer_index, dma_load, dma_command,
		underrun_total, readable_count, writeable_count, output ready);
endinterface

`default_nettype wire

@@ rtl/abrd_step.sv @@
// Next-state and response logic for one request against the ring state.
// Depends on abrd_pkg.
`default_nettype none

module abrd_step (
	input  wire abrd_pkg::state_t st,
	input  wire abrd_pkg::req_t   req,
	output abrd_pkg::state_t      nxt,
	output abrd_pkg::rsp_t        rsp
);
	import abrd_pkg::*;

	sval_t tx_busy;
	sval_t rx_busy;
	sval_t filled_s;
	sval_t nfilled_s;
	sval_t free_s;
	sval_t readable_s;
	ptr_t  idx;

	assign tx_busy    = busy_slots(req.tx_first_empty, req.tx_next_empty);
	assign rx_busy    = busy_slots(req.rx_first_empty, req.rx_next_empty);
	assign filled_s   = {2'b00, st.filled};
	assign free_s     = sval_t'(NUM_BUFFERS) - filled_s - tx_busy - rx_busy;
	assign readable_s = filled_s - rx_busy;

	always_comb begin
		nxt             = st;
		idx             = '0;
		rsp.granted     = 1'b0;
		rsp.dma_load    = LD_NONE;
		rsp.dma_command = CMD_NONE;
		unique case (func_t'(req.func))
			FN_CLAIM: begin
				if (free_s > 0) begin
					rsp.granted = 1'b1;
					idx         = st.wp;
					nxt.wp      = ptr_inc(st.wp);
					nxt.filled  = st.filled + fill_t'(1);
				end
			end
			FN_REFILL: begin
				if (req.tx_next_empty) begin
					if (req.tx_first_empty && !st.halted) begin
						nxt.halted      = 1'b1;
						nxt.underrun    = st.underrun + 16'd1;
						rsp.dma_command = CMD_DISABLE;
					end
					if (readable_s > 0) begin
						rsp.granted  = 1'b1;
						idx          = st.rp;
						nxt.rp       = ptr_inc(st.rp);
						nxt.filled   = st.filled - fill_t'(1);
						rsp.dma_load = req.tx_first_empty ? LD_FIRST : LD_NEXT;
					end
				end else if (st.halted &&
					readable_s == sval_t'(NUM_BUFFERS) - tx_busy - rx_busy) begin
					nxt.halted      = 1'b0;
					rsp.dma_command = CMD_ENABLE;
				end
			end
			FN_SRESET: begin
				nxt             = STATE_RST;
				rsp.dma_command = CMD_DISABLE;
			end
			default: begin
			end
		endcase
		nfilled_s           = {2'b00, nxt.filled};
		rsp.buffer_index    = IDX_W'(idx);
		rsp.underrun_total  = nxt.underrun;
		rsp.readable_count  = clamp_cnt(nfilled_s - rx_busy);
		rsp.writeable_count = clamp_cnt(sval_t'(NUM_BUFFERS) - nfilled_s - tx_busy -
			rx_busy);
	end

endmodule

`default_nettype wire

@@ rtl/audio_buffer_ring_dma_feeder.sv @@
// Top level of the audio buffer ring DMA feeder: request register, ring
// state and response register around abrd_step.
// Depends on abrd_pkg, abrd_req_if/abrd_rsp_if and abrd_step.
//
// Usage:
//   req: one request per handshake (claim, refill, soft reset, no-op) with the
//        empty flags of the transmit and receive DMA slots.
//   rsp: exactly one response per request, in order: grant and index,
//        DMA slot load, DMA enable/disable, underrun total and the
//        readable/writeable buffer counts after the request.
//   Path: a request taken into the request register moves on to the response
//   register when rsp is empty or being taken, and rsp shows it from there.
//   Throughput: one request per cycle while rsp is not stalled; the ring
//   state updates in a single pass when a request moves from the request
//   register to the response register.
//   Reset: pointers and counts clear, the DMA is marked halted, no request
//   or response is held.
//   Stall: while rsp is not taken the response holds; one more request is
//   held in the request register, after which req.ready drops.
`default_nettype none

module audio_buffer_ring_dma_feeder (
	input wire logic  clk,
	input wire logic  arst_n,
	abrd_req_if.sink  req,
	abrd_rsp_if.source rsp
);
	import abrd_pkg::*;

	logic   req_valid_s1;
	req_t   req_s1;
	logic   rsp_valid_s2;
	rsp_t   rsp_s2;
	state_t state_q;
	state_t state_nxt;
	rsp_t   rsp_nxt;
	logic   adv;

	assign adv       = req_valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !req_valid_s1 || adv;

	abrd_step u_step (
		.st  (state_q),
		.req (req_s1),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			state_q      <= STATE_RST;
		end else begin
			if (req.ready)
				req_valid_s1 <= req.valid;
			if (adv) begin
				rsp_valid_s2 <= 1'b1;
				state_q      <= state_nxt;
			end else if (rsp.ready) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			req_s1 <= '{func: req.func, tx_first_empty: req.tx_first_empty,
				tx_next_empty: req.tx_next_empty, rx_first_empty: req.rx_first_empty,
				rx_next_empty: req.rx_next_empty};
		if (adv)
			rsp_s2 <= rsp_nxt;
	end

	assign rsp.valid           = rsp_valid_s2;
	assign rsp.granted         = rsp_s2.granted;
	assign rsp.buffer_index    = rsp_s2.buffer_index;
	assign rsp.dma_load        = rsp_s2.dma_load;
	assign rsp.dma_command     = rsp_s2.dma_command;
	assign rsp.underrun_total  = rsp_s2.underrun_total;
	assign rsp.readable_count  = rsp_s2.readable_count;
	assign rsp.writeable_count = rsp_s2.writeable_count;

endmodule

`default_nettype wire

@@ rtl/abrd_checker.sv @@
// Port-level assertions for the audio buffer ring DMA feeder, bound to the top.
// Depends on abrd_pkg and audio_buffer_ring_dma_feeder.
`default_nettype none

module abrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        granted,
	input wire logic [2:0]  buffer_index,
	input wire logic [1:0]  dma_load,
	input wire logic [1:0]  dma_command,
	input wire logic [3:0]  readable_count,
	input wire logic [3:0]  writeable_count
);
	import abrd_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(buffer_index) && $stable(granted))
		else $error("response changed while stalled");

	a_no_grant_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !granted |-> buffer_index == 3'd0 && dma_load == LD_NONE)
		else $error("index or load without grant");

	a_load_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dma_load != LD_NONE |-> granted)
		else $error("slot load without a handed-out buffer");

	a_enable_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dma_command == CMD_ENABLE |-> !granted)
		else $error("enable together with grant");

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(readable_count) + int'(writeable_count)) <= NUM_BUFFERS)
		else $error("buffer counts exceed ring size");

endmodule

bind audio_buffer_ring_dma_feeder abrd_checker u_abrd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.granted         (rsp.granted),
	.buffer_index    (rsp.buffer_index),
	.dma_load        (rsp.dma_load),
	.dma_command     (rsp.dma_command),
	.readable_count  (rsp.readable_count),
	.writeable_count (rsp.writeable_count)
);

`default_nettype wire
